// ----- hw/rtl/c3s_pkg.sv -----
// c3s_pkg: shared constants, payload structs and window/kernel types for the
// streaming 3x3 convolution. Used by every module under hw/rtl.
package c3s_pkg;

	// fixed field widths
	localparam int PIXEL_BITS     = 16;
	localparam int COEF_BITS      = 16;
	localparam int POS_BITS       = 10;
	localparam int WIDTH_CFG_BITS = 11;
	localparam int KROW_BITS      = 3 * COEF_BITS;
	localparam int CFG_DATA_BITS  = 48;
	localparam int CFG_IDX_BITS   = 2;

	// defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int COEF_FRAC_BITS_DEF = 14;

	// register reset values and width limits
	localparam int                    WIDTH_RESET = 640;
	localparam int                    MIN_WIDTH   = 3;
	localparam logic [KROW_BITS-1:0] KTOP_RESET  = '0;
	localparam logic [KROW_BITS-1:0] KMID_RESET  = KROW_BITS'(16384);
	localparam logic [KROW_BITS-1:0] KBOT_RESET  = '0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_KERNEL_TOP    = 2'd1,
		CFG_KERNEL_MIDDLE = 2'd2,
		CFG_KERNEL_BOTTOM = 2'd3
	} cfg_idx_t;

	// 3x3 sample window: [row][col], row 0 oldest line, col 2 newest column
	typedef logic [2:0][2:0][PIXEL_BITS-1:0] win_t;

	// kernel coefficients: [row m][col n], signed Q2.14
	typedef logic [2:0][2:0][COEF_BITS-1:0] kernel_t;

	// input request
	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel_in;
		logic                         frame_start;
	} pix_t;

	// result request
	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel_out;
		logic [POS_BITS-1:0]          out_row;
		logic [POS_BITS-1:0]          out_col;
		logic                         on_border;
	} res_t;

	// window handed from the window stage to the multiply-accumulate pipe
	typedef struct packed {
		win_t                win;
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic                border;
	} win_item_t;

endpackage

// ----- hw/rtl/c3s_cfg.sv -----
// c3s_cfg: configuration registers (image width, three kernel rows).
// Depends on c3s_pkg. Width is clamped and stored as the last column index.
module c3s_cfg #(
	parameter int MAX_WIDTH = c3s_pkg::MAX_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [c3s_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [c3s_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	output logic [$clog2(MAX_WIDTH)-1:0]            width_last,
	output c3s_pkg::kernel_t                        kernel
);
	import c3s_pkg::*;

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int EW      = (CW + 1 > WIDTH_CFG_BITS) ? CW + 1 : WIDTH_CFG_BITS;
	localparam int RST_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	logic [EW-1:0]                 w_ext;
	logic [EW-1:0]                 w_eff;
	logic [CW-1:0]                 last_d;
	logic [CW-1:0]                 last_q;
	logic [2:0][KROW_BITS-1:0]     krow_q;

	// clamp the requested width into [3, MAX_WIDTH]
	always_comb begin
		w_ext = EW'(cfg_data[WIDTH_CFG_BITS-1:0]);
		if (w_ext < EW'(MIN_WIDTH)) begin
			w_eff = EW'(MIN_WIDTH);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		last_d = CW'(w_eff - EW'(1));
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= CW'(RST_EFF - 1);
			krow_q[0] <= KTOP_RESET;
			krow_q[1] <= KMID_RESET;
			krow_q[2] <= KBOT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:   last_q    <= last_d;
				CFG_KERNEL_TOP:    krow_q[0] <= cfg_data[KROW_BITS-1:0];
				CFG_KERNEL_MIDDLE: krow_q[1] <= cfg_data[KROW_BITS-1:0];
				CFG_KERNEL_BOTTOM: krow_q[2] <= cfg_data[KROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// split rows into coefficients, column 0 in the low bits
	always_comb begin
		for (int m = 0; m < 3; m++) begin
			for (int n = 0; n < 3; n++) begin
				kernel[m][n] = krow_q[m][n*COEF_BITS +: COEF_BITS];
			end
		end
	end

	assign cfg_ready  = 1'b1;
	assign width_last = last_q;

endmodule

// ----- hw/rtl/c3s_line_buf.sv -----
// c3s_line_buf: the two line stores as one memory of sample pairs, with a
// registered read and a same-address bypass. Depends on c3s_pkg.
module c3s_line_buf #(
	parameter int DEPTH = c3s_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [c3s_pkg::PIXEL_BITS-1:0]   wr_pix,
	output logic [c3s_pkg::PIXEL_BITS-1:0]   rd_above,
	output logic [c3s_pkg::PIXEL_BITS-1:0]   rd_above2
);
	import c3s_pkg::*;

	localparam int DW = 2 * PIXEL_BITS;

	// entry: upper half previous row, lower half the row before it
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] raw_q;
	logic [DW-1:0] byp_data_q;
	logic          byp_q;
	logic [DW-1:0] word;
	logic [DW-1:0] wr_word;

	// the previous row moves down one line, the new sample becomes the row above
	assign wr_word = {wr_pix, rd_above};

	// memory port, read registered; a write to the read address is forwarded
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			raw_q      <= mem[rd_addr];
			byp_q      <= wr_en && (wr_addr == rd_addr);
			byp_data_q <= wr_word;
		end
	end

	assign word      = byp_q ? byp_data_q : raw_q;
	assign rd_above  = word[DW-1:PIXEL_BITS];
	assign rd_above2 = word[PIXEL_BITS-1:0];

endmodule

// ----- hw/rtl/c3s_front.sv -----
// c3s_front: raster position counters, line-store access and the 3x3 window.
// Depends on c3s_pkg and c3s_line_buf.
module c3s_front #(
	parameter int MAX_WIDTH = c3s_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  c3s_pkg::pix_t                 pix,
	input  logic [$clog2(MAX_WIDTH)-1:0]  width_last,
	output logic                          item_valid,
	input  logic                          item_ready,
	output c3s_pkg::win_item_t            item
);
	import c3s_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]         col_q;
	logic [POS_BITS-1:0]   row_q;
	logic [CW-1:0]         c0;
	logic [CW-1:0]         cm1;
	logic [POS_BITS-1:0]   r0;
	logic [POS_BITS-1:0]   rm1;
	logic                  wrap;
	logic                  accept;

	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         addr_s1;
	logic                  emit_s1;
	logic [POS_BITS-1:0]   row_s1;
	logic [POS_BITS-1:0]   col_s1;
	logic                  border_s1;

	logic                  valid_s2;
	win_t                  win_s2;
	logic [POS_BITS-1:0]   row_s2;
	logic [POS_BITS-1:0]   col_s2;
	logic                  border_s2;

	logic                  ready_s1;
	logic                  ready_s2;
	logic                  adv1;
	logic [PIXEL_BITS-1:0] above;
	logic [PIXEL_BITS-1:0] above2;

	// handshake between stages
	assign ready_s2  = !valid_s2 || item_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign adv1      = valid_s1 && ready_s2;
	assign accept    = pix_valid && ready_s1;
	assign pix_stall = !ready_s1;

	// position of the incoming pixel
	always_comb begin
		c0   = pix.frame_start ? '0 : col_q;
		r0   = pix.frame_start ? '0 : row_q;
		cm1  = c0 - CW'(1);
		rm1  = r0 - POS_BITS'(1);
		wrap = (c0 >= width_last);
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= wrap ? '0 : c0 + CW'(1);
			row_q <= wrap ? r0 + POS_BITS'(1) : r0;
		end
	end

	// stage 1: pixel and center position while the line stores are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pix.pixel_in;
			addr_s1   <= c0;
			emit_s1   <= (r0 != '0) && (c0 != '0);
			row_s1    <= rm1;
			col_s1    <= POS_BITS'({{POS_BITS{1'b0}}, cm1});
			border_s1 <= (rm1 == '0) || (cm1 == '0);
		end
	end

	c3s_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (c0),
		.wr_en    (adv1),
		.wr_addr  (addr_s1),
		.wr_pix   (pix_s1),
		.rd_above (above),
		.rd_above2(above2)
	);

	// stage 2: window shift; only pixels that produce a result go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			win_s2   <= '0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= adv1 && emit_s1;
			end
			if (adv1) begin
				for (int i = 0; i < 3; i++) begin
					win_s2[i][0] <= win_s2[i][1];
					win_s2[i][1] <= win_s2[i][2];
				end
				win_s2[0][2] <= above2;
				win_s2[1][2] <= above;
				win_s2[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			border_s2 <= border_s1;
		end
	end

	assign item_valid  = valid_s2;
	assign item.win    = win_s2;
	assign item.row    = row_s2;
	assign item.col    = col_s2;
	assign item.border = border_s2;

	// a frame start puts the next pixel at column 1 of row 0
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix.frame_start |=> (col_q == CW'(1)) && (row_q == '0))
		else $error("frame start did not restart the raster position");

	// a pixel held in stage 1 keeps its line-store address until it moves on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(addr_s1))
		else $error("stage 1 lost or changed a waiting pixel");

	// a center on the first row is always a border position
	a_row0_border: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (row_s2 == '0) |-> border_s2)
		else $error("row 0 center not flagged as border");

endmodule

// ----- hw/rtl/c3s_mac.sv -----
// c3s_mac: nine products, row sums, final sum with floor shift and saturation
// into the result register; border positions give zero. Depends on c3s_pkg.
module c3s_mac #(
	parameter int COEF_FRAC_BITS = c3s_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c3s_pkg::kernel_t     kernel,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  c3s_pkg::win_item_t   item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output c3s_pkg::res_t        res
);
	import c3s_pkg::*;

	localparam int PW = PIXEL_BITS + COEF_BITS;
	localparam int RW = PW + 2;
	localparam int SW = PW + 4;
	localparam logic signed [SW-1:0] PIX_HI = SW'((1 << (PIXEL_BITS - 1)) - 1);
	localparam logic signed [SW-1:0] PIX_LO = -PIX_HI - SW'(1);

	logic                    v3;
	logic signed [PW-1:0]    prod_s3 [3][3];
	logic [POS_BITS-1:0]     row_s3;
	logic [POS_BITS-1:0]     col_s3;
	logic                    border_s3;

	logic                    v4;
	logic signed [RW-1:0]    rsum_s4 [3];
	logic [POS_BITS-1:0]     row_s4;
	logic [POS_BITS-1:0]     col_s4;
	logic                    border_s4;

	logic                    res_valid_q;
	res_t                    res_q;

	logic                    rdy3;
	logic                    rdy4;
	logic                    rdy5;
	logic signed [SW-1:0]    total;
	logic signed [SW-1:0]    shifted;
	logic [PIXEL_BITS-1:0]   sat;

	// stage handshake
	assign rdy5       = !res_valid_q || !res_stall;
	assign rdy4       = !v4 || rdy5;
	assign rdy3       = !v3 || rdy4;
	assign item_ready = rdy3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3          <= 1'b0;
			v4          <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy3) begin
				v3 <= item_valid;
			end
			if (rdy4) begin
				v4 <= v3;
			end
			if (rdy5) begin
				res_valid_q <= v4;
			end
		end
	end

	// stage 3: flipped kernel times window
	always_ff @(posedge clk) begin
		if (item_valid && rdy3) begin
			for (int m = 0; m < 3; m++) begin
				for (int n = 0; n < 3; n++) begin
					prod_s3[m][n] <= $signed(kernel[m][n]) * $signed(item.win[2-m][2-n]);
				end
			end
			row_s3    <= item.row;
			col_s3    <= item.col;
			border_s3 <= item.border;
		end
	end

	// stage 4: one sum per kernel row
	always_ff @(posedge clk) begin
		if (v3 && rdy4) begin
			for (int m = 0; m < 3; m++) begin
				rsum_s4[m] <= RW'(prod_s3[m][0]) + RW'(prod_s3[m][1]) + RW'(prod_s3[m][2]);
			end
			row_s4    <= row_s3;
			col_s4    <= col_s3;
			border_s4 <= border_s3;
		end
	end

	// final sum, floor shift, saturate
	always_comb begin
		total   = SW'(rsum_s4[0]) + SW'(rsum_s4[1]) + SW'(rsum_s4[2]);
		shifted = total >>> COEF_FRAC_BITS;
		if (shifted > PIX_HI) begin
			sat = PIXEL_BITS'(PIX_HI);
		end else if (shifted < PIX_LO) begin
			sat = PIXEL_BITS'(PIX_LO);
		end else begin
			sat = PIXEL_BITS'(shifted);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (v4 && rdy5) begin
			res_q.pixel_out <= border_s4 ? '0 : sat;
			res_q.out_row   <= row_s4;
			res_q.out_col   <= col_s4;
			res_q.on_border <= border_s4;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// border positions always give zero
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.on_border |-> (res.pixel_out == '0))
		else $error("border result is not zero");

	// a window taken from the front lands in the product stage
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> v3)
		else $error("accepted window lost before the product stage");

	// products wait in place while the row-sum stage is full
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v3 && !rdy4 |=> v3 && $stable(row_s3) && $stable(col_s3))
		else $error("product stage changed while blocked");

endmodule

// ----- hw/rtl/conv3x3_stream.sv -----
// conv3x3_stream: streaming 3x3 convolution, top level. Depends on c3s_pkg,
// c3s_cfg, c3s_front (with c3s_line_buf) and c3s_mac.
// Throughput: one pixel per clock while pix_stall is low; the line stores take
// one read and one write per cycle in their single memory. res_valid rises after
// a pixel passes the position, window, product, row-sum and result registers.
// Reset: counters, window and valid bits clear at once, registers take their
// defaults; the line stores are not cleared.
module conv3x3_stream #(
	parameter int MAX_WIDTH      = c3s_pkg::MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = c3s_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  c3s_pkg::pix_t                       pix,
	output logic                                res_valid,
	input  logic                                res_stall,
	output c3s_pkg::res_t                       res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [c3s_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [c3s_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import c3s_pkg::*;

	logic [$clog2(MAX_WIDTH)-1:0] width_last;
	kernel_t                      kernel;
	logic                         item_valid;
	logic                         item_ready;
	win_item_t                    item;

	// configuration registers
	c3s_cfg #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.width_last(width_last),
		.kernel    (kernel)
	);

	// position tracking, line stores and window
	c3s_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.width_last(width_last),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item)
	);

	// multiply-accumulate and result register
	c3s_mac #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.kernel    (kernel),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for conv3x3_stream, raster pixels in, window sums out
// depends on c3s_pkg and conv3x3_stream; results are checked against a predictor or given values
module testbench;
	import c3s_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RAND_ITEMS   = 520;
	localparam int STORE_DEPTH  = MAX_WIDTH_DEF;
	localparam int MAX_PRINTS   = 40;
	localparam longint PIX_HI   = (longint'(1) <<< (PIXEL_BITS - 1)) - 1;
	localparam longint PIX_LO   = -PIX_HI - 1;

	typedef enum logic [1:0] {RX_FREE, RX_SPARSE, RX_BURSTY} rx_mode_t;

	// one step of the directed sequence: a register write or a pixel request
	typedef struct packed {
		logic                         is_cfg;
		cfg_idx_t                     idx;
		logic [CFG_DATA_BITS-1:0]     data;
		logic signed [PIXEL_BITS-1:0] px;
		logic                         fs;
		logic                         typed;
		res_t                         want;
	} step_t;

	logic                     clk;
	logic                     arst_n;
	logic                     pix_valid;
	logic                     pix_stall;
	pix_t                     pix;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_t                     res;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// predictor state: registers, line stores, window and raster position
	logic [WIDTH_CFG_BITS-1:0]    img_width;
	logic [KROW_BITS-1:0]         krow [3];
	logic signed [PIXEL_BITS-1:0] line_a [STORE_DEPTH];
	logic signed [PIXEL_BITS-1:0] line_b [STORE_DEPTH];
	bit                           ok_a [STORE_DEPTH];
	bit                           ok_b [STORE_DEPTH];
	logic signed [PIXEL_BITS-1:0] win [3][3];
	int                           col_cnt;
	int                           row_cnt;

	res_t     pending_results [$];
	int       mismatch_cnt = 0;
	int       cycle_cnt = 0;
	bit       gaps_on = 1'b0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_run = 0;

	conv3x3_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// width register as the block sees it
	function automatic int eff_width(input logic [WIDTH_CFG_BITS-1:0] w);
		if (w < MIN_WIDTH)
			return MIN_WIDTH;
		if (w > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return int'(w);
	endfunction

	// advance the raster model by one pixel, return 1 with the result if one is due
	function automatic bit conv_predict(input pix_t p, output res_t r);
		int                           w;
		int                           c;
		int                           rr;
		longint                       acc;
		longint                       q;
		logic signed [COEF_BITS-1:0]  cf;
		bit                           emit;
		w = eff_width(img_width);
		if (p.frame_start) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = col_cnt;
		rr = row_cnt;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = line_b[c];
		win[1][2] = line_a[c];
		win[2][2] = p.pixel_in;
		line_b[c] = line_a[c];
		ok_b[c] = ok_a[c];
		line_a[c] = p.pixel_in;
		ok_a[c] = 1'b1;
		r = '0;
		emit = (rr >= 1) && (c >= 1);
		if (emit) begin
			r.out_row = POS_BITS'(rr - 1);
			r.out_col = POS_BITS'(c - 1);
			r.on_border = (rr == 1) || (c == 1);
			if (!r.on_border) begin
				// flipped kernel: coefficient (m,n) meets window cell (2-m,2-n)
				acc = 0;
				for (int m = 0; m < 3; m++)
					for (int n = 0; n < 3; n++) begin
						cf = krow[m][COEF_BITS*n +: COEF_BITS];
						acc += longint'(cf) * longint'(win[2-m][2-n]);
					end
				q = acc >>> COEF_FRAC_BITS_DEF;
				if (q > PIX_HI)
					q = PIX_HI;
				if (q < PIX_LO)
					q = PIX_LO;
				r.pixel_out = PIXEL_BITS'(q);
			end
		end
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (rr + 1) % (1 << POS_BITS);
		end else begin
			col_cnt = c + 1;
		end
		return emit;
	endfunction

	function automatic logic signed [PIXEL_BITS-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: return PIXEL_BITS'(int'($urandom_range(0, 8)) - 4);
			default: return PIXEL_BITS'($urandom);
		endcase
	endfunction

	// kernel row: corner values, rounding probes, small taps or anything
	function automatic logic [KROW_BITS-1:0] rand_krow();
		logic [KROW_BITS-1:0] k;
		k = '0;
		case ($urandom_range(0, 7))
			0: k = '0;
			1: k = '1;
			2: k = {3{16'h7fff}};
			3: k = {3{16'h8000}};
			4: k = {3{16'h0001}};
			5: begin
				for (int n = 0; n < 3; n++)
					k[COEF_BITS*n +: COEF_BITS] = COEF_BITS'(int'($urandom_range(0, 4096)) - 2048);
			end
			default: k = KROW_BITS'({$urandom, $urandom});
		endcase
		return k;
	endfunction

	function automatic step_t px_step(input logic signed [PIXEL_BITS-1:0] px, input logic fs);
		step_t s;
		s = '0;
		s.px = px;
		s.fs = fs;
		return s;
	endfunction

	function automatic step_t chk_step(input logic signed [PIXEL_BITS-1:0] px, input logic fs,
			input res_t want);
		step_t s;
		s = px_step(px, fs);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic step_t cfg_step(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_cnt < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_cnt, what);
		mismatch_cnt++;
	endtask

	// register write, called at a falling edge while the block is idle
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_IMAGE_WIDTH:   img_width = val[WIDTH_CFG_BITS-1:0];
			CFG_KERNEL_TOP:    krow[0] = val;
			CFG_KERNEL_MIDDLE: krow[1] = val;
			CFG_KERNEL_BOTTOM: krow[2] = val;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// present one pixel request and hold it until accepted
	task automatic push_pixel(input logic signed [PIXEL_BITS-1:0] px, input logic fs,
			input logic typed, input res_t want);
		pix_t req;
		res_t predicted;
		req.pixel_in = px;
		req.frame_start = fs;
		pix = req;
		pix_valid = 1'b1;
		do @(posedge clk); while (pix_stall !== 1'b0);
		if (conv_predict(req, predicted))
			pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// random pixels in bursts; the first one may open a frame
	task automatic run_pixels(input int n, input bit new_frame, input bit fs_noise);
		logic fs;
		for (int i = 0; i < n; i++) begin
			if (gaps_on && burst_left == 0) begin
				pix_valid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 32);
			end
			if (burst_left > 0)
				burst_left--;
			fs = (new_frame && i == 0) || (fs_noise && $urandom_range(0, 299) == 0);
			push_pixel(rand_pixel(), fs, 1'b0, '0);
		end
	endtask

	// stop sending, let every result and the tail of the pipe come out
	task automatic wait_idle();
		pix_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// result side stall pattern
	always @(negedge clk) begin
		case (rx_mode)
			RX_FREE:   res_stall = 1'b0;
			RX_SPARSE: res_stall = ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_run == 0) begin
					res_stall = ~res_stall;
					rx_run = $urandom_range(1, 12);
				end else begin
					rx_run--;
				end
			end
		endcase
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result (%0d,%0d) with nothing pending",
					res.out_row, res.out_col));
			end else begin
				want = pending_results.pop_front();
				if (res.pixel_out !== want.pixel_out)
					report_mismatch($sformatf("pixel_out at (%0d,%0d): got %0d, want %0d",
						want.out_row, want.out_col, res.pixel_out, want.pixel_out));
				if (res.out_row !== want.out_row)
					report_mismatch($sformatf("out_row: got %0d, want %0d",
						res.out_row, want.out_row));
				if (res.out_col !== want.out_col)
					report_mismatch($sformatf("out_col: got %0d, want %0d",
						res.out_col, want.out_col));
				if (res.on_border !== want.on_border)
					report_mismatch($sformatf("on_border at (%0d,%0d): got %0b, want %0b",
						want.out_row, want.out_col, res.on_border, want.on_border));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[conv3x3_stream] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		step_t                steps [$];
		int                   n;
		int                   w_new;
		int                   we;
		bit                   fresh;
		bit                   fits;
		int                   rand_sent;
		// every input known from time zero
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		img_width = WIDTH_CFG_BITS'(WIDTH_RESET);
		krow[0] = KTOP_RESET;
		krow[1] = KMID_RESET;
		krow[2] = KBOT_RESET;
		for (int c = 0; c < STORE_DEPTH; c++) begin
			line_a[c] = '0;
			line_b[c] = '0;
			ok_a[c] = 1'b0;
			ok_b[c] = 1'b0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		col_cnt = 0;
		row_cnt = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: width below range, reset kernel (copy of the right neighbor)
		steps.push_back(cfg_step(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(0)));
		steps.push_back(px_step(16'sh7fff, 1'b1));
		steps.push_back(px_step(16'sh8000, 1'b0));
		steps.push_back(px_step(16'sh0001, 1'b0));
		steps.push_back(px_step(16'shffff, 1'b0));
		steps.push_back(chk_step(16'sh1234, 1'b0, {16'h0000, 10'd0, 10'd0, 1'b1}));
		steps.push_back(chk_step(16'sh8000, 1'b0, {16'h0000, 10'd0, 10'd1, 1'b1}));
		steps.push_back(px_step(16'sh7fff, 1'b0));
		steps.push_back(chk_step(16'sh0000, 1'b0, {16'h0000, 10'd1, 10'd0, 1'b1}));
		steps.push_back(chk_step(16'sh5555, 1'b0, {16'h8000, 10'd1, 10'd1, 1'b0}));
		// new frame at width 4 with an all minus-one bottom row: floor of negative sums
		steps.push_back(cfg_step(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(4)));
		steps.push_back(cfg_step(CFG_KERNEL_BOTTOM, {CFG_DATA_BITS{1'b1}}));
		steps.push_back(px_step(16'sh0003, 1'b1));
		steps.push_back(px_step(16'sh0002, 1'b0));
		steps.push_back(px_step(16'shfffe, 1'b0));
		steps.push_back(px_step(16'sh7fff, 1'b0));
		steps.push_back(px_step(16'sh8000, 1'b0));
		steps.push_back(chk_step(16'sh0001, 1'b0, {16'h0000, 10'd0, 10'd0, 1'b1}));
		steps.push_back(px_step(16'sh0004, 1'b0));
		steps.push_back(px_step(16'shffff, 1'b0));
		steps.push_back(px_step(16'sh0005, 1'b0));
		steps.push_back(px_step(16'sh8000, 1'b0));
		steps.push_back(px_step(16'sh7fff, 1'b0));
		steps.push_back(px_step(16'sh0010, 1'b0));
		steps.push_back(px_step(16'shfff0, 1'b0));
		steps.push_back(px_step(16'sh0100, 1'b0));
		steps.push_back(px_step(16'sh7ffe, 1'b0));
		// narrow the row while the column sits past the new width
		steps.push_back(cfg_step(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(MIN_WIDTH)));
		steps.push_back(px_step(16'sh0040, 1'b0));
		steps.push_back(px_step(16'sh8001, 1'b0));
		steps.push_back(px_step(16'sh0002, 1'b0));

		rx_mode = RX_SPARSE;
		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				wait_idle();
				write_reg(steps[i].idx, steps[i].data);
			end else begin
				push_pixel(steps[i].px, steps[i].fs, steps[i].typed, steps[i].want);
			end
		end

		// random phases: fresh frames or a continued frame with new settings
		rand_sent = 0;
		fresh = 1'b1;
		while (rand_sent < RAND_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 1))
				write_reg(CFG_KERNEL_TOP, rand_krow());
			if ($urandom_range(0, 1))
				write_reg(CFG_KERNEL_MIDDLE, rand_krow());
			if ($urandom_range(0, 1))
				write_reg(CFG_KERNEL_BOTTOM, rand_krow());
			if (fresh) begin
				case ($urandom_range(0, 9))
					0: w_new = $urandom_range(0, MIN_WIDTH - 1);
					1: w_new = $urandom_range(41, 300);
					default: w_new = $urandom_range(MIN_WIDTH, 40);
				endcase
				write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w_new));
				we = eff_width(WIDTH_CFG_BITS'(w_new));
				if (we <= 40)
					n = we * $urandom_range(2, 6) + $urandom_range(0, we - 1);
				else
					n = we * 2 + $urandom_range(1, we);
			end else begin
				// mid-frame width change only where both line stores hold real rows
				if ($urandom_range(0, 1)) begin
					w_new = $urandom_range(0, eff_width(img_width) + 4);
					fits = 1'b1;
					for (int c = 0; c < eff_width(WIDTH_CFG_BITS'(w_new)); c++)
						if (!(ok_a[c] && ok_b[c]))
							fits = 1'b0;
					if (fits)
						write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w_new));
				end
				n = $urandom_range(5, 80);
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			run_pixels(n, fresh, 1'b1);
			rand_sent += n;
			fresh = ($urandom_range(0, 1) == 0);
		end

		// width above range acts as the full line store
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'((1 << WIDTH_CFG_BITS) - 1));
		run_pixels(MAX_WIDTH_DEF + 8, 1'b1, 1'b0);
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(MAX_WIDTH_DEF));
		run_pixels(40, 1'b1, 1'b0);
		wait_idle();

		if (mismatch_cnt == 0)
			$display("[conv3x3_stream] OK");
		else
			$display("[conv3x3_stream] ERROR");
		$finish;
	end

endmodule
